// ----- sv/bez_pkg.sv -----
// shared constants, types and register codes of the bezier evaluate-and-split block
package bez_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int T_FRAC_BITS   = 16;
    localparam int T_WIDTH       = T_FRAC_BITS + 1;
    localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
    localparam int PROD_WIDTH    = DIFF_WIDTH + T_WIDTH + 1;

    localparam int AXES          = 2;
    localparam int AX_X          = 0;
    localparam int AX_Y          = 1;
    localparam int NUM_PTS       = 4;
    localparam int NUM_REGS      = AXES * NUM_PTS;
    localparam int CFG_IDX_WIDTH = $clog2(NUM_REGS);

    localparam int LEVELS        = 3;
    localparam int LEVEL_STAGES  = 3;
    localparam int NUM_STAGES    = LEVELS * LEVEL_STAGES;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic        [T_WIDTH-1:0]     t_param;

    localparam t_param T_ONE = t_param'(1) << T_FRAC_BITS;
    localparam logic [PROD_WIDTH-1:0] ROUND_HALF =
        {{(PROD_WIDTH-T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
        REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y
    } t_reg_idx;

    // enables of the three stages of one interpolation level
    typedef struct packed {
        logic diff;
        logic mul;
        logic sum;
    } t_lerp_en;

    // per-stage advance enables and occupancy of the pipeline
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

// ----- sv/bez_cfg.sv -----
// control point register file, written through the configuration port
module bez_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bez_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  bez_pkg::t_coord                  i_cfg_data,
    output bez_pkg::t_coord                  o_pts [bez_pkg::AXES][bez_pkg::NUM_PTS]
);
    import bez_pkg::*;

    t_coord r_pts [AXES][NUM_PTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                for (int p = 0; p < NUM_PTS; p++) begin
                    r_pts[a][p] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_P0_X: r_pts[AX_X][0] <= i_cfg_data;
                REG_P0_Y: r_pts[AX_Y][0] <= i_cfg_data;
                REG_P1_X: r_pts[AX_X][1] <= i_cfg_data;
                REG_P1_Y: r_pts[AX_Y][1] <= i_cfg_data;
                REG_P2_X: r_pts[AX_X][2] <= i_cfg_data;
                REG_P2_Y: r_pts[AX_Y][2] <= i_cfg_data;
                REG_P3_X: r_pts[AX_X][3] <= i_cfg_data;
                REG_P3_Y: r_pts[AX_Y][3] <= i_cfg_data;
            endcase
        end
    end

    assign o_pts = r_pts;

endmodule

// ----- sv/bez_ctl.sv -----
// valid bits and stall-collapsing advance enables of the pipeline
module bez_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready,
    output bez_pkg::t_pipe_ctl o_ctl
);
    import bez_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] en;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en  = en;
    assign o_ctl.vld = r_vld;

endmodule

// ----- sv/bez_lerp.sv -----
// one rounded interpolation a + (b - a) * t over difference, multiply and sum stages
module bez_lerp (
    input  logic              i_clk,
    input  bez_pkg::t_lerp_en i_en,
    input  bez_pkg::t_coord   i_a,
    input  bez_pkg::t_coord   i_b,
    input  bez_pkg::t_param   i_t,
    output bez_pkg::t_coord   o_res
);
    import bez_pkg::*;

    t_diff                 r_d;
    t_coord                r_a1;
    t_prod                 r_p;
    t_coord                r_a2;
    t_coord                r_res;
    logic [PROD_WIDTH-1:0] n_sum;

    // i_t belongs to the item in the difference register
    always_ff @(posedge i_clk) begin
        if (i_en.diff) begin
            r_d  <= t_diff'(i_b) - t_diff'(i_a);
            r_a1 <= i_a;
        end
        if (i_en.mul) begin
            r_p  <= r_d * $signed({1'b0, i_t});
            r_a2 <= r_a1;
        end
        if (i_en.sum) begin
            r_res <= r_a2 + t_coord'(n_sum[T_FRAC_BITS +: COORD_WIDTH]);
        end
    end

    // floor((d*t + half) / one) rounds both signs alike
    assign n_sum = r_p + ROUND_HALF;
    assign o_res = r_res;

endmodule

// ----- sv/cubic_bezier_eval_split.sv -----
// top level: cubic bezier evaluation and split at t by de casteljau interpolation
//
// Each input beat carries t (unsigned, 1.0 = 2^16, larger values clamp to 1.0) and gives one
// output beat with the curve point at t and the inner control points of both halves, for x and
// y side by side. The four control points are configuration registers (index 0..7 = p0_x, p0_y,
// ... p3_y, reset 0); write them only while no beat is in flight. The pipeline is nine register
// stages deep: three interpolation levels, each a difference, a 33 x 18 multiply and a rounding
// add. One beat is taken every cycle while the last stage is empty or its result is accepted.
// While a result waits, earlier stages still move into empty slots, so input is taken as long
// as any stage is empty; nine waiting beats close the input.
module cubic_bezier_eval_split (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bez_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  bez_pkg::t_coord                   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  bez_pkg::t_param                   i_param_t,
    output logic                              o_valid,
    input  logic                              i_ready,
    output bez_pkg::t_coord                   o_point_x,
    output bez_pkg::t_coord                   o_point_y,
    output bez_pkg::t_coord                   o_left_ctrl1_x,
    output bez_pkg::t_coord                   o_left_ctrl1_y,
    output bez_pkg::t_coord                   o_left_ctrl2_x,
    output bez_pkg::t_coord                   o_left_ctrl2_y,
    output bez_pkg::t_coord                   o_right_ctrl1_x,
    output bez_pkg::t_coord                   o_right_ctrl1_y,
    output bez_pkg::t_coord                   o_right_ctrl2_x,
    output bez_pkg::t_coord                   o_right_ctrl2_y
);
    import bez_pkg::*;

    localparam int T_DLY = 2 * LEVEL_STAGES + 1;   // t is needed up to the last level's entry
    localparam int Q_DLY = 2 * LEVEL_STAGES;       // first-level points ride past two levels
    localparam int S_DLY = LEVEL_STAGES;           // second-level points ride past one level

    t_coord    pts [AXES][NUM_PTS];
    t_pipe_ctl ctl;
    t_lerp_en  en_lvl [LEVELS];
    t_param    t_sat;

    // level outputs, per axis
    t_coord q0 [AXES];
    t_coord q1 [AXES];
    t_coord q2 [AXES];
    t_coord s0 [AXES];
    t_coord s1 [AXES];
    t_coord pt [AXES];

    // t travels with its beat; side points wait for the point to finish
    t_param r_t    [T_DLY];
    t_coord r_q0_d [Q_DLY][AXES];
    t_coord r_q2_d [Q_DLY][AXES];
    t_coord r_s0_d [S_DLY][AXES];
    t_coord r_s1_d [S_DLY][AXES];

    bez_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pts      (pts)
    );

    bez_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ctl   (ctl)
    );

    assign o_ready = ctl.en[0];
    assign o_valid = ctl.vld[NUM_STAGES-1];

    // clamp t above one
    assign t_sat = (i_param_t[T_FRAC_BITS] && (|i_param_t[T_FRAC_BITS-1:0])) ? T_ONE : i_param_t;

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl_en
        assign en_lvl[l] = '{diff: ctl.en[l*LEVEL_STAGES],
                             mul:  ctl.en[l*LEVEL_STAGES+1],
                             sum:  ctl.en[l*LEVEL_STAGES+2]};
    end

    for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
        // first level: straight from the control points
        bez_lerp u_q0 (.i_clk(i_clk), .i_en(en_lvl[0]), .i_a(pts[ax][0]), .i_b(pts[ax][1]),
                       .i_t(r_t[0]), .o_res(q0[ax]));
        bez_lerp u_q1 (.i_clk(i_clk), .i_en(en_lvl[0]), .i_a(pts[ax][1]), .i_b(pts[ax][2]),
                       .i_t(r_t[0]), .o_res(q1[ax]));
        bez_lerp u_q2 (.i_clk(i_clk), .i_en(en_lvl[0]), .i_a(pts[ax][2]), .i_b(pts[ax][3]),
                       .i_t(r_t[0]), .o_res(q2[ax]));
        // second level
        bez_lerp u_s0 (.i_clk(i_clk), .i_en(en_lvl[1]), .i_a(q0[ax]), .i_b(q1[ax]),
                       .i_t(r_t[LEVEL_STAGES]), .o_res(s0[ax]));
        bez_lerp u_s1 (.i_clk(i_clk), .i_en(en_lvl[1]), .i_a(q1[ax]), .i_b(q2[ax]),
                       .i_t(r_t[LEVEL_STAGES]), .o_res(s1[ax]));
        // third level: the curve point
        bez_lerp u_pt (.i_clk(i_clk), .i_en(en_lvl[2]), .i_a(s0[ax]), .i_b(s1[ax]),
                       .i_t(r_t[2*LEVEL_STAGES]), .o_res(pt[ax]));
    end

    // payload only, no reset; each register follows its stage's enable
    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_t[0] <= t_sat;
        end
        for (int k = 1; k < T_DLY; k++) begin
            if (ctl.en[k]) begin
                r_t[k] <= r_t[k-1];
            end
        end

        for (int ax = 0; ax < AXES; ax++) begin
            if (ctl.en[LEVEL_STAGES]) begin
                r_q0_d[0][ax] <= q0[ax];
                r_q2_d[0][ax] <= q2[ax];
            end
            for (int k = 1; k < Q_DLY; k++) begin
                if (ctl.en[LEVEL_STAGES+k]) begin
                    r_q0_d[k][ax] <= r_q0_d[k-1][ax];
                    r_q2_d[k][ax] <= r_q2_d[k-1][ax];
                end
            end

            if (ctl.en[2*LEVEL_STAGES]) begin
                r_s0_d[0][ax] <= s0[ax];
                r_s1_d[0][ax] <= s1[ax];
            end
            for (int k = 1; k < S_DLY; k++) begin
                if (ctl.en[2*LEVEL_STAGES+k]) begin
                    r_s0_d[k][ax] <= r_s0_d[k-1][ax];
                    r_s1_d[k][ax] <= r_s1_d[k-1][ax];
                end
            end
        end
    end

    // all outputs come straight from the last stage registers
    assign o_point_x       = pt[AX_X];
    assign o_point_y       = pt[AX_Y];
    assign o_left_ctrl1_x  = r_q0_d[Q_DLY-1][AX_X];
    assign o_left_ctrl1_y  = r_q0_d[Q_DLY-1][AX_Y];
    assign o_left_ctrl2_x  = r_s0_d[S_DLY-1][AX_X];
    assign o_left_ctrl2_y  = r_s0_d[S_DLY-1][AX_Y];
    assign o_right_ctrl1_x = r_s1_d[S_DLY-1][AX_X];
    assign o_right_ctrl1_y = r_s1_d[S_DLY-1][AX_Y];
    assign o_right_ctrl2_x = r_q2_d[Q_DLY-1][AX_X];
    assign o_right_ctrl2_y = r_q2_d[Q_DLY-1][AX_Y];

`ifndef SYNTHESIS
    // an empty output stage lets every stage move, so input is open
    a_empty_out_opens_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked while the output stage is empty");

    // t held in the first stage is never above one
    a_t_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.vld[0] |-> (r_t[0] <= T_ONE))
        else $error("parameter not clamped to one");

    // the curve point lies between the two second-level points
    a_point_between_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_left_ctrl2_x <= o_point_x && o_point_x <= o_right_ctrl1_x) ||
                     (o_right_ctrl1_x <= o_point_x && o_point_x <= o_left_ctrl2_x)))
        else $error("point x outside its interpolation span");

    a_point_between_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_left_ctrl2_y <= o_point_y && o_point_y <= o_right_ctrl1_y) ||
                     (o_right_ctrl1_y <= o_point_y && o_point_y <= o_left_ctrl2_y)))
        else $error("point y outside its interpolation span");
`endif

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the cubic bezier evaluate-and-split pipeline
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bez_pkg::*;

    // one result beat: ten coordinates, x and y interleaved as on the ports
    typedef enum int {
        F_POINT_X, F_POINT_Y, F_LC1_X, F_LC1_Y, F_LC2_X, F_LC2_Y,
        F_RC1_X, F_RC1_Y, F_RC2_X, F_RC2_Y, F_COUNT
    } t_field;

    typedef logic [F_COUNT-1:0][COORD_WIDTH-1:0]   t_split;
    typedef logic [NUM_REGS-1:0][COORD_WIDTH-1:0]  t_curve;

    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam int     SETTLE_CYCLES = 2 * NUM_STAGES;

    string field_name [F_COUNT] = '{
        "point_x", "point_y", "left_ctrl1_x", "left_ctrl1_y", "left_ctrl2_x",
        "left_ctrl2_y", "right_ctrl1_x", "right_ctrl1_y", "right_ctrl2_x", "right_ctrl2_y"
    };

    // every block input has a known value from time zero
    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx  = '0;
    t_coord                   i_cfg_data = '0;
    logic                     i_valid    = 1'b0;
    t_param                   i_param_t  = '0;
    logic                     i_ready    = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    t_coord o_point_x, o_point_y, o_left_ctrl1_x, o_left_ctrl1_y, o_left_ctrl2_x;
    t_coord o_left_ctrl2_y, o_right_ctrl1_x, o_right_ctrl1_y, o_right_ctrl2_x;
    t_coord o_right_ctrl2_y;

    cubic_bezier_eval_split i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_param_t       (i_param_t),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_left_ctrl1_x  (o_left_ctrl1_x),
        .o_left_ctrl1_y  (o_left_ctrl1_y),
        .o_left_ctrl2_x  (o_left_ctrl2_x),
        .o_left_ctrl2_y  (o_left_ctrl2_y),
        .o_right_ctrl1_x (o_right_ctrl1_x),
        .o_right_ctrl1_y (o_right_ctrl1_y),
        .o_right_ctrl2_x (o_right_ctrl2_x),
        .o_right_ctrl2_y (o_right_ctrl2_y)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the control point registers, kept from the observed write port
    t_coord ctrl_reg [NUM_REGS];
    t_split pending_splits [$];
    int     mismatch_count = 0;
    int     beats_out      = 0;
    int     curves_loaded  = 0;
    int     send_idle_pct  = 29;
    int     recv_idle_pct  = 55;
    int     stall_req      = 0;
    int     stall_left     = 0;

    initial foreach (ctrl_reg[i]) ctrl_reg[i] = '0;

    // one interpolation step: a + round((b - a) * t), ties towards plus infinity
    // an arithmetic shift of the biased product gives the floor for either sign of b - a
    function automatic longint lerp_at(longint a, longint b, longint t);
        longint prod;
        prod = (b - a) * t + (longint'(1) <<< (T_FRAC_BITS - 1));
        return a + (prod >>> T_FRAC_BITS);
    endfunction

    // three de casteljau levels per axis on the shadow registers
    function automatic t_split predict_split(t_param raw_t);
        t_split r;
        longint t, p0, p1, p2, p3, q0, q1, q2, s0, s1, pt;
        // a parameter above one is taken as exactly one
        t = (raw_t > T_ONE) ? longint'(T_ONE) : longint'(raw_t);
        for (int ax = 0; ax < AXES; ax++) begin
            p0 = ctrl_reg[int'(REG_P0_X) + ax];
            p1 = ctrl_reg[int'(REG_P1_X) + ax];
            p2 = ctrl_reg[int'(REG_P2_X) + ax];
            p3 = ctrl_reg[int'(REG_P3_X) + ax];
            q0 = lerp_at(p0, p1, t);
            q1 = lerp_at(p1, p2, t);
            q2 = lerp_at(p2, p3, t);
            s0 = lerp_at(q0, q1, t);
            s1 = lerp_at(q1, q2, t);
            pt = lerp_at(s0, s1, t);
            r[int'(F_POINT_X) + ax] = t_coord'(pt);
            r[int'(F_LC1_X) + ax]   = t_coord'(q0);
            r[int'(F_LC2_X) + ax]   = t_coord'(s0);
            r[int'(F_RC1_X) + ax]   = t_coord'(s1);
            r[int'(F_RC2_X) + ax]   = t_coord'(q2);
        end
        return r;
    endfunction

    // scoreboard: output beats are checked first, then accepted input beats are predicted,
    // all in one process so the queue sees a fixed order within a step
    always @(posedge i_clk) begin
        t_split got, want;
        if (!i_rst_n) begin
            foreach (ctrl_reg[i]) ctrl_reg[i] = '0;
        end else begin
            if (o_valid && i_ready) begin
                got[F_POINT_X] = o_point_x;
                got[F_POINT_Y] = o_point_y;
                got[F_LC1_X]   = o_left_ctrl1_x;
                got[F_LC1_Y]   = o_left_ctrl1_y;
                got[F_LC2_X]   = o_left_ctrl2_x;
                got[F_LC2_Y]   = o_left_ctrl2_y;
                got[F_RC1_X]   = o_right_ctrl1_x;
                got[F_RC1_Y]   = o_right_ctrl1_y;
                got[F_RC2_X]   = o_right_ctrl2_x;
                got[F_RC2_Y]   = o_right_ctrl2_y;
                beats_out++;
                if (pending_splits.size() == 0) begin
                    $error("output beat with no prediction pending");
                    mismatch_count++;
                end else begin
                    want = pending_splits.pop_front();
                    for (int f = 0; f < F_COUNT; f++) begin
                        if (got[f] !== want[f]) begin
                            $error("%s: expected %0d, got %0d", field_name[f],
                                   $signed(want[f]), $signed(got[f]));
                            mismatch_count++;
                        end
                    end
                end
            end
            if (i_valid && o_ready)
                pending_splits.push_back(predict_split(i_param_t));
            if (i_cfg_we)
                ctrl_reg[i_cfg_idx] = i_cfg_data;
        end
    end

    // output side: random back-pressure, plus a long hold-off counted here on request
    always @(posedge i_clk) begin
        if (stall_req != 0) begin
            stall_left <= stall_req;
            stall_req = 0;
            i_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one parameter beat, with a random gap first; returns at the accepting edge
    // with valid still high, so the caller either sends again or drops it in the same step
    task automatic send_param(input t_param t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid   <= 1'b0;
            i_param_t <= t_param'($urandom);
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_param_t <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // let the pipeline empty so the registers may change; one edge first so that
    // the scoreboard has queued the beat taken at the edge we were called on
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_splits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all eight control point registers, one per cycle
    task automatic program_curve(input t_curve c);
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(i);
            i_cfg_data <= c[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        curves_loaded++;
    endtask

    // coordinates biased towards the range ends, zero and small values
    function automatic t_coord random_coord();
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3, 4:    return t_coord'(int'($urandom_range(4095)) - 2048);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // mostly in [0, 1], some exact ends, some anywhere in the 17 bits to hit the clamp
    function automatic t_param random_t();
        case ($urandom_range(19))
            0:       return '0;
            1:       return T_ONE;
            2, 3, 4: return t_param'($urandom);
            default: return t_param'($urandom_range(int'(T_ONE)));
        endcase
    endfunction

    // registers straight out of reset: every result must be zero
    task automatic test_reset_state();
        send_param('0);
        send_param(T_ONE);
        send_param(t_param'(1) << (T_FRAC_BITS - 1));
        send_param('1);
        wait_idle();
    endtask

    // full-scale swings, rounding ties and a flat curve
    task automatic test_directed_extremes();
        t_curve c;
        // zig-zag between the coordinate extremes, y in opposite phase
        c[REG_P0_X] = COORD_MIN; c[REG_P1_X] = COORD_MAX;
        c[REG_P2_X] = COORD_MIN; c[REG_P3_X] = COORD_MAX;
        c[REG_P0_Y] = COORD_MAX; c[REG_P1_Y] = COORD_MIN;
        c[REG_P2_Y] = COORD_MAX; c[REG_P3_Y] = COORD_MIN;
        program_curve(c);
        send_param('0);
        send_param(t_param'(1));
        send_param(t_param'(17'h07fff));
        send_param(t_param'(17'h08000));
        send_param(t_param'(17'h08001));
        send_param(t_param'(17'h0ffff));
        send_param(T_ONE);
        send_param(t_param'(17'h10001));
        send_param(t_param'(17'h1ffff));
        send_param(t_param'(17'h15555));
        wait_idle();
        // unit steps so that half-way products land exactly on a tie, both signs
        c[REG_P0_X] = '0; c[REG_P1_X] = t_coord'(1);
        c[REG_P2_X] = '0; c[REG_P3_X] = t_coord'(1);
        c[REG_P0_Y] = '0; c[REG_P1_Y] = t_coord'(-1);
        c[REG_P2_Y] = '0; c[REG_P3_Y] = t_coord'(-1);
        program_curve(c);
        send_param(t_param'(17'h08000));
        send_param(t_param'(17'h04000));
        send_param(t_param'(17'h0c000));
        send_param(t_param'(1));
        send_param(t_param'(17'h0ffff));
        wait_idle();
        // degenerate curve: all points equal at the extremes
        for (int i = 0; i < NUM_REGS; i++)
            c[i] = (i % AXES == AX_X) ? COORD_MAX : COORD_MIN;
        program_curve(c);
        send_param(t_param'(17'h08000));
        send_param(t_param'(17'h1aaaa));
        wait_idle();
    endtask

    // bulk random traffic in three idling phases, new curve every segment
    task automatic test_random_phases();
        t_curve c;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 29; recv_idle_pct = 55; end
                1:       begin send_idle_pct = 55; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int seg = 0; seg < 8; seg++) begin
                for (int i = 0; i < NUM_REGS; i++) c[i] = random_coord();
                program_curve(c);
                repeat (60) send_param(random_t());
                wait_idle();
            end
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and refuse input
    task automatic test_backpressure();
        t_curve c;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < NUM_REGS; i++) c[i] = random_coord();
        program_curve(c);
        // request at the falling edge, away from the receiver's sampling edge
        @(negedge i_clk);
        stall_req = 300;
        @(posedge i_clk);
        repeat (80) send_param(random_t());
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_extremes();
        test_random_phases();
        test_backpressure();
        $display("checked %0d result beats over %0d control point settings,",
                 beats_out, curves_loaded);
        $display("with extremes, rounding ties, clamped t and a long output stall");
        if (mismatch_count == 0 && pending_splits.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
